### rtl/pl0ts_pkg.sv
// ----------------------------------------------------------------------------
// pl0ts_pkg: shared types and constants of the PL/0 token scanner
// Token codes, result item layout and the keyword lookup.
// ----------------------------------------------------------------------------
`default_nettype none

package pl0ts_pkg;

	localparam int PREFIX_DEPTH = 9;
	localparam int PREFIX_IW    = $clog2(PREFIX_DEPTH);
	localparam int NUM_KW       = 14;

	typedef enum logic [4:0] {
		TK_IDENT, TK_NUMBER, TK_PLUS, TK_MINUS, TK_MULT, TK_SLASH, TK_ODD, TK_EQ,
		TK_NEQ, TK_LESS, TK_LEQ, TK_GTR, TK_GEQ, TK_LPAREN, TK_RPAREN, TK_COMMA,
		TK_SEMI, TK_PERIOD, TK_BECOMES, TK_BEGIN, TK_END, TK_IF, TK_THEN, TK_WHILE,
		TK_DO, TK_CALL, TK_CONST, TK_INT, TK_PROC, TK_WRITE, TK_READ, TK_ELSE
	} tok_code_t;

	typedef logic [PREFIX_DEPTH-1:0][7:0] prefix_t;

	typedef struct packed {
		tok_code_t   code;
		logic [15:0] start;
		logic [7:0]  length;
		logic        last;
	} tok_t;

	typedef struct packed {
		logic [1:0] valid;
		tok_t       first;
		tok_t       second;
	} tok_pair_t;

	localparam logic [8*PREFIX_DEPTH-1:0] KW_TEXT [NUM_KW] = '{
		"begin", "while", "const", "write", "call", "then", "procedure",
		"read", "else", "odd", "end", "int", "if", "do"
	};
	localparam int KW_LEN [NUM_KW] = '{5, 5, 5, 5, 4, 4, 9, 4, 4, 3, 3, 3, 2, 2};
	localparam tok_code_t KW_CODE [NUM_KW] = '{
		TK_BEGIN, TK_WHILE, TK_CONST, TK_WRITE, TK_CALL, TK_THEN, TK_PROC,
		TK_READ, TK_ELSE, TK_ODD, TK_END, TK_INT, TK_IF, TK_DO
	};

	function automatic tok_code_t kw_lookup(input prefix_t prefix, input logic short_word,
			input logic [PREFIX_IW-1:0] len);
		tok_code_t code;
		logic      hit;
		code = TK_IDENT;
		for (int k = 0; k < NUM_KW; k++) begin
			hit = short_word && (len == PREFIX_IW'(KW_LEN[k]));
			for (int i = 0; i < PREFIX_DEPTH; i++) begin
				if (i < KW_LEN[k]) begin
					if (prefix[i] != KW_TEXT[k][8*(KW_LEN[k]-1-i) +: 8])
						hit = 1'b0;
				end
			end
			if (hit)
				code = KW_CODE[k];
		end
		return code;
	endfunction

endpackage

`default_nettype wire

### rtl/pl0ts_if.sv
// ----------------------------------------------------------------------------
// pl0ts_if: channels of the PL/0 token scanner
// Source byte channel and token result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface pl0ts_src_if;
	logic       valid;
	logic       ready;
	logic [7:0] source_byte;
	logic       end_of_source;

	modport source (output valid, source_byte, end_of_source, input ready);
	modport sink   (input valid, source_byte, end_of_source, output ready);
endinterface

interface pl0ts_tok_if;
	logic        valid;
	logic        ready;
	logic [4:0]  token_code;
	logic [15:0] token_start;
	logic [7:0]  token_length;
	logic        last_of_run;

	modport source (output valid, token_code, token_start, token_length, last_of_run,
		input ready);
	modport sink   (input valid, token_code, token_start, token_length, last_of_run,
		output ready);
endinterface

`default_nettype wire

### rtl/pl0ts_scan.sv
// ----------------------------------------------------------------------------
// pl0ts_scan: input register and scan state of the PL/0 token scanner
// Registers one source byte, advances the scan state and produces up to two
// tokens per byte for the result queue.
// ----------------------------------------------------------------------------
`default_nettype none

module pl0ts_scan #(
	parameter int MAX_SOURCE_BYTES = 65536,
	parameter int MAX_TOKEN_LEN    = 255
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	pl0ts_src_if.sink          src,
	input  wire logic          room,
	output pl0ts_pkg::tok_pair_t push
);
	import pl0ts_pkg::*;

	localparam int POS_W = $clog2(MAX_SOURCE_BYTES);
	localparam int LEN_W = $clog2(MAX_TOKEN_LEN + 2);
	localparam logic [POS_W-1:0] POS_LAST  = POS_W'(MAX_SOURCE_BYTES - 1);
	localparam logic [LEN_W-1:0] RUN_MAX   = LEN_W'(MAX_TOKEN_LEN + 1);
	localparam logic [LEN_W-1:0] LEN_MAX   = LEN_W'(MAX_TOKEN_LEN);
	localparam logic [LEN_W-1:0] RUN_SHORT = LEN_W'(PREFIX_DEPTH);

	typedef enum logic [2:0] {MODE_IDLE, MODE_WORD, MODE_NUMBER, MODE_PEND, MODE_COMMENT} mode_t;
	typedef enum logic [1:0] {SYM_SLASH, SYM_LT, SYM_GT, SYM_COLON} sym_t;

	function automatic logic [15:0] to16(input logic [POS_W-1:0] p);
		logic [POS_W+15:0] w;
		w = {16'd0, p};
		return w[15:0];
	endfunction

	function automatic logic [7:0] rep_len(input logic [LEN_W-1:0] r);
		logic [LEN_W+7:0] w;
		w = {8'd0, (r > LEN_MAX) ? LEN_MAX : r};
		return w[7:0];
	endfunction

	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             eos_s1;
	logic             fire;

	mode_t            mode_q, mode_n;
	sym_t             pend_q, pend_n;
	logic [POS_W-1:0] pos_q, pos_n, start_q, start_n;
	logic [LEN_W-1:0] run_q, run_n;
	prefix_t          prefix_q, prefix_n;
	logic             star_q, star_n;

	logic             is_letter, is_digit, is_space, is_wordc, consumed;
	logic             a_vld, b_vld, c_vld;
	tok_t             a_tok, b_tok, c_tok, bc_tok;

	assign fire      = valid_s1 & room;
	assign src.ready = ~valid_s1 | room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (src.ready) begin
			valid_s1 <= src.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (src.ready && src.valid) begin
			byte_s1 <= src.source_byte;
			eos_s1  <= src.end_of_source;
		end
	end

	assign is_letter = (byte_s1 >= "a" && byte_s1 <= "z") || (byte_s1 >= "A" && byte_s1 <= "Z");
	assign is_digit  = byte_s1 >= "0" && byte_s1 <= "9";
	assign is_space  = byte_s1 == " " || (byte_s1 >= 8'd9 && byte_s1 <= 8'd13);
	assign is_wordc  = is_letter | is_digit | (byte_s1 == "_");

	always_comb begin
		mode_n   = mode_q;
		pend_n   = pend_q;
		start_n  = start_q;
		run_n    = run_q;
		prefix_n = prefix_q;
		star_n   = star_q;
		consumed = 1'b0;
		a_vld    = 1'b0;
		b_vld    = 1'b0;
		c_vld    = 1'b0;
		a_tok    = '{code: TK_IDENT, start: to16(start_q), length: 8'd1, last: 1'b0};
		b_tok    = '{code: TK_IDENT, start: to16(pos_q), length: 8'd1, last: 1'b0};
		c_tok    = '{code: TK_IDENT, start: to16(start_q), length: 8'd1, last: 1'b0};

		unique case (mode_q)
			MODE_WORD: begin
				if (is_wordc) begin
					if (run_q < RUN_SHORT)
						prefix_n[run_q[PREFIX_IW-1:0]] = byte_s1;
					if (run_q < RUN_MAX)
						run_n = run_q + 1'b1;
					consumed = 1'b1;
				end else begin
					a_vld        = 1'b1;
					a_tok.code   = kw_lookup(prefix_q, run_q <= RUN_SHORT,
						run_q[PREFIX_IW-1:0]);
					a_tok.length = rep_len(run_q);
					mode_n       = MODE_IDLE;
				end
			end
			MODE_NUMBER: begin
				if (is_digit) begin
					if (run_q < RUN_MAX)
						run_n = run_q + 1'b1;
					consumed = 1'b1;
				end else begin
					a_vld        = 1'b1;
					a_tok.code   = TK_NUMBER;
					a_tok.length = rep_len(run_q);
					mode_n       = MODE_IDLE;
				end
			end
			MODE_PEND: begin
				a_tok.length = 8'd2;
				priority if (pend_q == SYM_GT && byte_s1 == "=") begin
					a_vld      = 1'b1;
					a_tok.code = TK_GEQ;
					consumed   = 1'b1;
					mode_n     = MODE_IDLE;
				end else if (pend_q == SYM_LT && byte_s1 == "=") begin
					a_vld      = 1'b1;
					a_tok.code = TK_LEQ;
					consumed   = 1'b1;
					mode_n     = MODE_IDLE;
				end else if (pend_q == SYM_LT && byte_s1 == ">") begin
					a_vld      = 1'b1;
					a_tok.code = TK_NEQ;
					consumed   = 1'b1;
					mode_n     = MODE_IDLE;
				end else if (pend_q == SYM_COLON && byte_s1 == "=") begin
					a_vld      = 1'b1;
					a_tok.code = TK_BECOMES;
					consumed   = 1'b1;
					mode_n     = MODE_IDLE;
				end else if (pend_q == SYM_SLASH && byte_s1 == "*") begin
					consumed = 1'b1;
					mode_n   = MODE_COMMENT;
					star_n   = 1'b0;
				end else begin
					a_vld        = pend_q != SYM_COLON;
					a_tok.length = 8'd1;
					a_tok.code   = (pend_q == SYM_SLASH) ? TK_SLASH :
						(pend_q == SYM_LT) ? TK_LESS : TK_GTR;
					mode_n       = MODE_IDLE;
					star_n       = 1'b0;
				end
			end
			MODE_COMMENT: begin
				consumed = 1'b1;
				if (byte_s1 == "/" && star_q) begin
					mode_n = MODE_IDLE;
					star_n = 1'b0;
				end else begin
					star_n = byte_s1 == "*";
				end
			end
			MODE_IDLE: begin
				mode_n = MODE_IDLE;
			end
			default: begin
				mode_n = MODE_IDLE;
			end
		endcase

		if (!consumed && !is_space) begin
			priority if (is_letter) begin
				mode_n      = MODE_WORD;
				start_n     = pos_q;
				run_n       = LEN_W'(1);
				prefix_n[0] = byte_s1;
			end else if (is_digit) begin
				mode_n  = MODE_NUMBER;
				start_n = pos_q;
				run_n   = LEN_W'(1);
			end else if (byte_s1 == "/" || byte_s1 == "<" || byte_s1 == ">"
					|| byte_s1 == ":") begin
				mode_n  = MODE_PEND;
				start_n = pos_q;
				pend_n  = (byte_s1 == "/") ? SYM_SLASH : (byte_s1 == "<") ? SYM_LT :
					(byte_s1 == ">") ? SYM_GT : SYM_COLON;
			end else begin
				b_vld = 1'b1;
				unique case (byte_s1)
					"+":     b_tok.code = TK_PLUS;
					"-":     b_tok.code = TK_MINUS;
					"*":     b_tok.code = TK_MULT;
					"=":     b_tok.code = TK_EQ;
					"(":     b_tok.code = TK_LPAREN;
					")":     b_tok.code = TK_RPAREN;
					",":     b_tok.code = TK_COMMA;
					";":     b_tok.code = TK_SEMI;
					".":     b_tok.code = TK_PERIOD;
					default: b_vld = 1'b0;
				endcase
			end
		end

		if (eos_s1) begin
			c_tok.start = to16(start_n);
			unique case (mode_n)
				MODE_WORD: begin
					c_vld        = 1'b1;
					c_tok.code   = kw_lookup(prefix_n, run_n <= RUN_SHORT,
						run_n[PREFIX_IW-1:0]);
					c_tok.length = rep_len(run_n);
				end
				MODE_NUMBER: begin
					c_vld        = 1'b1;
					c_tok.code   = TK_NUMBER;
					c_tok.length = rep_len(run_n);
				end
				MODE_PEND: begin
					c_vld      = pend_n != SYM_COLON;
					c_tok.code = (pend_n == SYM_SLASH) ? TK_SLASH :
						(pend_n == SYM_LT) ? TK_LESS : TK_GTR;
				end
				default: c_vld = 1'b0;
			endcase
			mode_n = MODE_IDLE;
			star_n = 1'b0;
			pos_n  = '0;
		end else begin
			pos_n = (pos_q == POS_LAST) ? '0 : pos_q + 1'b1;
		end
	end

	always_comb begin
		bc_tok            = b_vld ? b_tok : c_tok;
		push.valid        = fire ? {a_vld & (b_vld | c_vld), a_vld | b_vld | c_vld} : 2'b00;
		push.first        = a_vld ? a_tok : bc_tok;
		push.first.last   = ~(a_vld & (b_vld | c_vld));
		push.second       = bc_tok;
		push.second.last  = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			pend_q  <= SYM_SLASH;
			pos_q   <= '0;
			start_q <= '0;
			run_q   <= '0;
			star_q  <= 1'b0;
		end else if (fire) begin
			mode_q  <= mode_n;
			pend_q  <= pend_n;
			pos_q   <= pos_n;
			start_q <= start_n;
			run_q   <= run_n;
			star_q  <= star_n;
		end
	end

	always_ff @(posedge clk) begin
		if (fire)
			prefix_q <= prefix_n;
	end

endmodule

`default_nettype wire

### rtl/pl0ts_resq.sv
// ----------------------------------------------------------------------------
// pl0ts_resq: result queue of the PL/0 token scanner
// Four-entry queue that takes up to two tokens a cycle and delivers one while tok.ready is high.
// ----------------------------------------------------------------------------
`default_nettype none

module pl0ts_resq (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire pl0ts_pkg::tok_pair_t  push,
	output logic                       room,
	pl0ts_tok_if.source                tok
);
	import pl0ts_pkg::*;

	localparam int DEPTH = 4;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);

	tok_t          ent_q [DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;
	logic          pop;
	logic [1:0]    npush;
	tok_t          head;

	assign room  = cnt_q <= CW'(DEPTH - 2);
	assign pop   = tok.valid & tok.ready;
	assign npush = {1'b0, push.valid[0]} + {1'b0, push.valid[1]};
	assign head  = ent_q[rd_q];

	assign tok.valid        = cnt_q != '0;
	assign tok.token_code   = head.code;
	assign tok.token_start  = head.start;
	assign tok.token_length = head.length;
	assign tok.last_of_run  = head.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + AW'(npush);
			rd_q  <= rd_q + AW'(pop);
			cnt_q <= cnt_q + CW'(npush) - CW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push.valid[0])
			ent_q[wr_q] <= push.first;
		if (push.valid[1])
			ent_q[wr_q + AW'(1)] <= push.second;
	end

endmodule

`default_nettype wire

### rtl/pl0_token_scanner_top.sv
// ----------------------------------------------------------------------------
// pl0_token_scanner_top: PL/0 token scanner
// Byte-serial lexer: one source byte in, zero to two tokens out.
// ----------------------------------------------------------------------------
//  channel | dir | fields                                            | handshake
//  src     | in  | source_byte[7:0], end_of_source                   | valid/ready
//  tok     | out | token_code[4:0], token_start[15:0],               | valid/ready
//          |     | token_length[7:0], last_of_run                    |
//
//  One byte is accepted per cycle while src.ready is high; its tokens pass
//  from the input register to the queue. Of a byte's two tokens, the first
//  has last_of_run low. src.ready drops when the input register is full and
//  the four-entry result queue has fewer than two free slots.
//  Reset clears scan state, positions and the queue; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module pl0_token_scanner_top #(
	parameter int MAX_SOURCE_BYTES = 65536,
	parameter int MAX_TOKEN_LEN    = 255
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	pl0ts_src_if.sink   src,
	pl0ts_tok_if.source tok
);
	import pl0ts_pkg::*;

	tok_pair_t push;
	logic      room;

	pl0ts_scan #(
		.MAX_SOURCE_BYTES (MAX_SOURCE_BYTES),
		.MAX_TOKEN_LEN    (MAX_TOKEN_LEN)
	) u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.src    (src),
		.room   (room),
		.push   (push)
	);

	pl0ts_resq u_resq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.room   (room),
		.tok    (tok)
	);

endmodule

`default_nettype wire

### rtl/pl0ts_chk.sv
// ----------------------------------------------------------------------------
// pl0ts_chk: port checker of the PL/0 token scanner
// Token length rules per code, and a held result while stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module pl0ts_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        tok_valid,
	input wire logic        tok_ready,
	input wire logic [4:0]  token_code,
	input wire logic [7:0]  token_length,
	input wire logic        last_of_run
);
	import pl0ts_pkg::*;

	a_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid |-> token_length != 8'd0)
		else $error("token of zero length");

	a_pair_len: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && (token_code == TK_NEQ || token_code == TK_LEQ ||
		token_code == TK_GEQ || token_code == TK_BECOMES) |-> token_length == 8'd2)
		else $error("two-byte operator with wrong length");

	a_kw_len: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && (token_code == TK_ODD || token_code >= TK_BEGIN)
		|-> token_length >= 8'd2 && token_length <= 8'd9)
		else $error("keyword with impossible length");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && !tok_ready |=> tok_valid && $stable(token_code)
		&& $stable(token_length) && $stable(last_of_run))
		else $error("stalled item changed");

endmodule

bind pl0_token_scanner_top pl0ts_chk u_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.tok_valid    (tok.valid),
	.tok_ready    (tok.ready),
	.token_code   (tok.token_code),
	.token_length (tok.token_length),
	.last_of_run  (tok.last_of_run)
);

`default_nettype wire
